@@ rtl/q32a_pkg.sv @@
// Package: operation codes, widths and transaction types of the Q32.32 ALU.
`default_nettype none
package q32a_pkg;

	localparam int unsigned DATA_W    = 64;
	localparam int unsigned FRAC_W    = 32;
	localparam int unsigned INT_W     = DATA_W - FRAC_W;
	localparam int unsigned DIV_STEPS = DATA_W;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic signed [INT_W-1:0]  integer_part;
		logic                     divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		req_t              ctl;
		logic [DATA_W-1:0] divisor;
		logic              neg_q;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
	} div_st_t;

endpackage
`default_nettype wire

@@ rtl/q32_fixed_point_alu.sv @@
// Top level of the pipelined Q32.32 fixed-point ALU.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req  (kind, operand_a, operand_b)
//   rsp      out        rsp_valid / rsp_ready  rsp  (result_value, integer_part,
//                                                    divide_by_zero)
//
// A request passes through the reciprocal pipeline (operand magnitude,
// 64 restoring-division steps, scaling), the multiplier and the output
// register. One transaction is accepted per cycle while no result is held.
// Reset clears all valid bits and the division stages; other payload registers
// are not reset.
// A held result stalls the whole pipeline in place; nothing is dropped.
`default_nettype none
module q32_fixed_point_alu (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire q32a_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output q32a_pkg::rsp_t      rsp
);
	import q32a_pkg::*;

	logic              en;
	logic              rc_valid;
	req_t              rc_ctl;
	logic [DATA_W-1:0] rc_recip;
	logic              m_valid;
	logic [DATA_W-1:0] m_result;
	logic              m_dz;

	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	q32a_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (req_valid),
		.ctl_in    (req),
		.valid_out (rc_valid),
		.ctl_out   (rc_ctl),
		.recip     (rc_recip)
	);

	q32a_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (rc_valid),
		.ctl_in    (rc_ctl),
		.recip     (rc_recip),
		.valid_out (m_valid),
		.result    (m_result),
		.dz        (m_dz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= m_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.result_value   <= m_result;
			rsp.integer_part   <= m_result[DATA_W-1:FRAC_W]
			                      + INT_W'(m_result[DATA_W-1] && (m_result[FRAC_W-1:0] != '0));
			rsp.divide_by_zero <= m_dz;
		end
	end

endmodule
`default_nettype wire

@@ rtl/q32a_div_stage.sv @@
// One restoring-division step: one quotient bit per pipeline stage.
`default_nettype none
module q32a_div_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              dbit,
	input  wire q32a_pkg::div_st_t st_in,
	output q32a_pkg::div_st_t      st_out
);
	import q32a_pkg::*;

	logic [DATA_W:0] trial;
	logic            fits;
	div_st_t         nxt;

	assign trial = {st_in.rem, dbit} - {1'b0, st_in.divisor};
	assign fits  = !trial[DATA_W];

	always_comb begin
		nxt     = st_in;
		nxt.rem = fits ? trial[DATA_W-1:0] : {st_in.rem[DATA_W-2:0], dbit};
		nxt.quo = {st_in.quo[DATA_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_out <= '0;
		end else if (en) begin
			st_out <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/q32a_recip.sv @@
// Reciprocal pipeline: -((-2^63 / B) * 2) through a chain of division steps.
`default_nettype none
module q32a_recip (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      valid_in,
	input  wire q32a_pkg::req_t            ctl_in,
	output logic                           valid_out,
	output q32a_pkg::req_t                 ctl_out,
	output logic [q32a_pkg::DATA_W-1:0]    recip
);
	import q32a_pkg::*;

	div_st_t           stage_s [0:DIV_STEPS];
	logic [DATA_W-1:0] dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s[0] <= '0;
		end else if (en) begin
			stage_s[0].valid   <= valid_in;
			stage_s[0].ctl     <= ctl_in;
			stage_s[0].divisor <= ctl_in.operand_b[DATA_W-1] ? DATA_W'(-ctl_in.operand_b)
			                                                 : ctl_in.operand_b;
			stage_s[0].neg_q   <= !ctl_in.operand_b[DATA_W-1];
			stage_s[0].rem     <= '0;
			stage_s[0].quo     <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		q32a_div_stage u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.dbit   (k == 0),
			.st_in  (stage_s[k]),
			.st_out (stage_s[k+1])
		);
	end

	assign dbl = {stage_s[DIV_STEPS].quo[DATA_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= stage_s[DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out <= stage_s[DIV_STEPS].ctl;
			recip   <= stage_s[DIV_STEPS].neg_q ? dbl : DATA_W'(-dbl);
		end
	end

endmodule
`default_nettype wire

@@ rtl/q32a_mult.sv @@
// Split-operand Q32.32 multiplier and result select, four pipeline stages.
`default_nettype none
module q32a_mult (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         valid_in,
	input  wire q32a_pkg::req_t               ctl_in,
	input  wire logic [q32a_pkg::DATA_W-1:0]  recip,
	output logic                              valid_out,
	output logic [q32a_pkg::DATA_W-1:0]       result,
	output logic                              dz
);
	import q32a_pkg::*;

	logic [DATA_W-1:0]        y;
	logic                     x_adj;
	logic                     y_adj;
	logic [DATA_W-1:0]        simple;
	logic signed [2*FRAC_W:0] t_c;
	logic [DATA_W-1:0]        frac_q;

	logic                     valid_s1, valid_s2, valid_s3;
	logic [2:0]               kind_s1, kind_s2, kind_s3;
	logic                     dz_s1, dz_s2, dz_s3;
	logic [DATA_W-1:0]        simple_s1, simple_s2, simple_s3;
	logic signed [INT_W-1:0]  xi_s1;
	logic signed [FRAC_W:0]   xf_s1;
	logic signed [INT_W-1:0]  yi_s1;
	logic signed [FRAC_W:0]   yf_s1;
	logic [FRAC_W-1:0]        ylo_s1;
	logic signed [INT_W-1:0]  yhi_s1;
	logic signed [DATA_W:0]   p0_s2;
	logic signed [DATA_W-1:0] p1_s2;
	logic signed [DATA_W:0]   p2_s2;
	logic signed [DATA_W+1:0] p3_s2;
	logic [DATA_W-1:0]        part_s3;
	logic [DATA_W-1:0]        frac_s3;

	assign y     = (ctl_in.kind == OP_DIV) ? recip : ctl_in.operand_b;
	assign x_adj = ctl_in.operand_a[DATA_W-1] && (ctl_in.operand_a[FRAC_W-1:0] != '0);
	assign y_adj = y[DATA_W-1] && (y[FRAC_W-1:0] != '0);

	always_comb begin
		case (ctl_in.kind)
			OP_ADD:  simple = ctl_in.operand_a + ctl_in.operand_b;
			OP_SUB:  simple = ctl_in.operand_a - ctl_in.operand_b;
			OP_NEG:  simple = DATA_W'(-ctl_in.operand_a);
			default: simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_s1  <= valid_in;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_out <= valid_s3;
		end
	end

	assign t_c    = $signed({p3_s2[DATA_W-1], p3_s2[DATA_W-1:0]});
	assign frac_q = p3_s2[DATA_W-1]
	                ? DATA_W'((t_c + $signed((2*FRAC_W+1)'({FRAC_W{1'b1}}))) >>> FRAC_W)
	                : DATA_W'(t_c >>> FRAC_W);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= ctl_in.kind;
			dz_s1     <= (ctl_in.kind == OP_DIV) && (ctl_in.operand_b == '0);
			simple_s1 <= simple;
			xi_s1     <= ctl_in.operand_a[DATA_W-1:FRAC_W] + INT_W'(x_adj);
			xf_s1     <= {x_adj, ctl_in.operand_a[FRAC_W-1:0]};
			yi_s1     <= y[DATA_W-1:FRAC_W] + INT_W'(y_adj);
			yf_s1     <= {y_adj, y[FRAC_W-1:0]};
			ylo_s1    <= y[FRAC_W-1:0];
			yhi_s1    <= y[DATA_W-1:FRAC_W];

			kind_s2   <= kind_s1;
			dz_s2     <= dz_s1;
			simple_s2 <= simple_s1;
			p0_s2     <= xi_s1 * $signed({1'b0, ylo_s1});
			p1_s2     <= xi_s1 * yhi_s1;
			p2_s2     <= xf_s1 * yi_s1;
			p3_s2     <= xf_s1 * yf_s1;

			kind_s3   <= kind_s2;
			dz_s3     <= dz_s2;
			simple_s3 <= simple_s2;
			part_s3   <= p0_s2[DATA_W-1:0] + {p1_s2[FRAC_W-1:0], {FRAC_W{1'b0}}}
			             + p2_s2[DATA_W-1:0];
			frac_s3   <= frac_q;

			dz        <= dz_s3;
			if (dz_s3) begin
				result <= '0;
			end else if (kind_s3 == OP_MUL || kind_s3 == OP_DIV) begin
				result <= part_s3 + frac_s3;
			end else begin
				result <= simple_s3;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/q32a_checker.sv @@
// Port-level checker for the Q32.32 ALU and its bind.
`default_nettype none
module q32a_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire q32a_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire q32a_pkg::rsp_t rsp
);
	import q32a_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp dropped or changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid || rsp_ready) |-> req_ready)
		else $error("req stalled without a held rsp");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0 && rsp.integer_part == '0)
		else $error("divide by zero with nonzero result");

	a_int_part: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.integer_part == rsp.result_value[DATA_W-1:FRAC_W]
			+ INT_W'(rsp.result_value[DATA_W-1] && (rsp.result_value[FRAC_W-1:0] != '0)))
		else $error("integer part mismatch");

endmodule

bind q32_fixed_point_alu q32a_checker u_q32a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

@@ test/tb_q32_fixed_point_alu.sv @@
// Testbench: Q32.32 ALU checked against a behavioral predictor under random handshake idling.
`default_nettype none
module tb_q32_fixed_point_alu;
	import q32a_pkg::*;

	localparam int LATENCY = 71;
	localparam longint unsigned CYCLE_LIMIT = 400000;
	localparam logic signed [63:0] Q_ONE = 64'sh1_0000_0000;
	localparam logic signed [63:0] RAW_MIN = {1'b1, 63'd0};
	localparam logic signed [63:0] RAW_MAX = {1'b0, {63{1'b1}}};

	typedef struct {
		req_t req;
		logic has_exp;
		rsp_t exp;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	rsp_t expected_rsps[$];
	int errors = 0;
	longint unsigned cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	q32_fixed_point_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] a_frac, a_int, acc;
		a_frac = a % Q_ONE;
		a_int = a / Q_ONE;
		acc = a_int * b;
		acc = acc + a_frac * (b / Q_ONE);
		acc = acc + (a_frac * (b % Q_ONE)) / Q_ONE;
		return acc;
	endfunction

	function automatic logic signed [63:0] fx_recip(logic signed [63:0] b);
		logic signed [63:0] q;
		if (b == -64'sd1) begin
			q = RAW_MIN;
		end else begin
			q = RAW_MIN / b;
		end
		q = q * 64'sd2;
		return -q;
	endfunction

	function automatic rsp_t alu_predict(req_t r);
		rsp_t o;
		logic signed [63:0] res, ip;
		res = '0;
		o.divide_by_zero = 1'b0;
		case (r.kind)
			OP_ADD: res = r.operand_a + r.operand_b;
			OP_SUB: res = r.operand_a - r.operand_b;
			OP_MUL: res = fx_mul(r.operand_a, r.operand_b);
			OP_DIV: begin
				if (r.operand_b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					res = fx_mul(r.operand_a, fx_recip(r.operand_b));
				end
			end
			OP_NEG: res = -r.operand_a;
			default: res = '0;
		endcase
		ip = res / Q_ONE;
		o.result_value = res;
		o.integer_part = ip[31:0];
		return o;
	endfunction

	function automatic logic signed [63:0] rand_operand();
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = RAW_MIN;
			1: v = RAW_MAX;
			2: v = '0;
			3: v = $signed(v) >>> $urandom_range(1, 63);
			4: v = {{32{v[31]}}, v[31:0]};
			5: v = -64'sd1;
			6: v = $signed({{40{v[23]}}, v[23:0]}) <<< 32;
			default: ;
		endcase
		return v;
	endfunction

	task automatic send(req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsps.insert(expected_rsps.size(), alu_predict(r));
	endtask

	task automatic send_idle(req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		send(r);
	endtask

	vec_t directed[$];

	function automatic req_t mk(logic [2:0] k, logic signed [63:0] a, logic signed [63:0] b);
		req_t r;
		r.kind = k;
		r.operand_a = a;
		r.operand_b = b;
		return r;
	endfunction

	function automatic rsp_t mkr(logic signed [63:0] v, logic signed [31:0] ip, logic dz);
		rsp_t o;
		o.result_value = v;
		o.integer_part = ip;
		o.divide_by_zero = dz;
		return o;
	endfunction

	task automatic add_row(req_t r, logic has, rsp_t e);
		vec_t v;
		v.req = r;
		v.has_exp = has;
		v.exp = e;
		directed.insert(directed.size(), v);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_q32_fixed_point_alu failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result %h", rsp);
				errors++;
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.result_value !== e.result_value) begin
					$error("result_value expected %h actual %h", e.result_value, rsp.result_value);
					errors++;
				end
				if (rsp.integer_part !== e.integer_part) begin
					$error("integer_part expected %h actual %h", e.integer_part, rsp.integer_part);
					errors++;
				end
				if (rsp.divide_by_zero !== e.divide_by_zero) begin
					$error("divide_by_zero expected %b actual %b", e.divide_by_zero,
						rsp.divide_by_zero);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		rsp_t e;
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(mk(OP_ADD, Q_ONE, Q_ONE), 1, mkr(64'sh2_0000_0000, 32'sd2, 1'b0));
		add_row(mk(OP_ADD, RAW_MAX, 64'sd1), 1, mkr(RAW_MIN, 32'sh8000_0000, 1'b0));
		add_row(mk(OP_SUB, RAW_MIN, 64'sd1), 1, mkr(RAW_MAX, 32'sh7fff_ffff, 1'b0));
		add_row(mk(OP_SUB, '0, Q_ONE), 1, mkr(-Q_ONE, -32'sd1, 1'b0));
		add_row(mk(OP_MUL, Q_ONE, 64'sh3_8000_0000), 1, mkr(64'sh3_8000_0000, 32'sd3, 1'b0));
		add_row(mk(OP_MUL, RAW_MIN, RAW_MIN), 0, e);
		add_row(mk(OP_MUL, RAW_MAX, RAW_MAX), 0, e);
		add_row(mk(OP_MUL, -64'sh1_8000_0000, 64'sh2_4000_0000), 0, e);
		add_row(mk(OP_DIV, Q_ONE, '0), 1, mkr('0, '0, 1'b1));
		add_row(mk(OP_DIV, RAW_MAX, '0), 1, mkr('0, '0, 1'b1));
		add_row(mk(OP_DIV, Q_ONE, -64'sd1), 1, mkr('0, '0, 1'b0));
		add_row(mk(OP_DIV, 64'sh6_0000_0000, 64'sh2_0000_0000), 0, e);
		add_row(mk(OP_DIV, RAW_MIN, 64'sd1), 0, e);
		add_row(mk(OP_DIV, RAW_MAX, RAW_MIN), 0, e);
		add_row(mk(OP_DIV, -64'sh7_0000_0000, 64'sh3_0000_0000), 0, e);
		add_row(mk(OP_NEG, RAW_MIN, RAW_MAX), 1, mkr(RAW_MIN, 32'sh8000_0000, 1'b0));
		add_row(mk(OP_NEG, Q_ONE, '0), 1, mkr(-Q_ONE, -32'sd1, 1'b0));
		add_row(mk(OP_NEG, 64'sh8000_0000, '0), 1, mkr(-64'sh8000_0000, '0, 1'b0));
		add_row(mk(3'd5, RAW_MAX, '0), 1, mkr('0, '0, 1'b0));
		add_row(mk(3'd6, RAW_MIN, '0), 1, mkr('0, '0, 1'b0));
		add_row(mk(3'd7, -64'sd1, -64'sd1), 1, mkr('0, '0, 1'b0));
		add_row(mk(OP_ADD, -64'sd1, -64'sd1), 1, mkr(-64'sd2, '0, 1'b0));

		foreach (directed[i]) begin
			if (directed[i].has_exp && alu_predict(directed[i].req) !== directed[i].exp) begin
				$error("directed row %0d predictor expected %h actual %h", i,
					directed[i].exp, alu_predict(directed[i].req));
				errors++;
			end
			send(directed[i].req);
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				3: begin send_idle_pct = 30; recv_stall_pct = 30; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 300; end
			endcase
			for (int n = 0; n < 266; n++) begin
				k = $urandom_range(0, 9);
				send_idle(mk(k < 9 ? 3'(k % 5) : 3'($urandom_range(5, 7)),
					rand_operand(), ($urandom_range(0, 15) == 0) ? '0 : rand_operand()));
			end
		end
		req_valid <= 1'b0;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("tb_q32_fixed_point_alu passed");
		end else begin
			$display("tb_q32_fixed_point_alu failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
